// ----- design/positional_stereo_gain_mixer_defines.svh -----
// Assertion helpers included by the top-level mixer.
`ifndef POSITIONAL_STEREO_GAIN_MIXER_DEFINES_SVH
`define POSITIONAL_STEREO_GAIN_MIXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PSGM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PSGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/psgm_pkg.sv -----
`default_nettype none
package psgm_pkg;

  localparam int ROUNDS = 17;
  localparam logic [4:0] ROUND_LAST = 5'(ROUNDS - 1);
  localparam logic [4:0] SQUARE_LAST = 5'd3;
  localparam logic [31:0] CORDIC_K_Q30 = 32'd652032874;
  localparam int R2_W = 64;
  localparam logic [R2_W-1:0] NEAR_LIMIT = 64'd1310720;
  localparam int NUM_W = 39;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);
  localparam logic [15:0] UNITY_GAIN = 16'd32768;
  localparam logic [15:0] FACING_RESET = 16'd16384;
  localparam logic [15:0] VOLUME_RESET = 16'd32768;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FACING = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd7;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] mix_left_in;
    logic signed [15:0] mix_right_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] mix_left_out;
    logic signed [15:0] mix_right_out;
  } out_beat_t;

  typedef struct packed {
    logic        ready;
    logic [15:0] left;
    logic [15:0] right;
  } gains_t;

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_angle(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0: a = 32'd536870912;
      5'd1: a = 32'd316933406;
      5'd2: a = 32'd167458907;
      5'd3: a = 32'd85004756;
      5'd4: a = 32'd42667331;
      5'd5: a = 32'd21354465;
      5'd6: a = 32'd10679838;
      5'd7: a = 32'd5340245;
      5'd8: a = 32'd2670163;
      5'd9: a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- design/psgm_divider.sv -----
`default_nettype none
module psgm_divider
  import psgm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             flush,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [R2_W-1:0]  den,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [R2_W-1:0]      rem;
  logic [R2_W-1:0]      den_q;
  logic [R2_W:0]        trial;
  logic                 fits;

  assign trial = {rem, quotient[NUM_W-1]};
  assign fits = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, numerator shifts out of the top
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den_q    <= den;
      quotient <= num;
    end else if (busy) begin
      rem      <= fits ? R2_W'(trial - {1'b0, den_q}) : trial[R2_W-1:0];
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- design/psgm_gain_engine.sv -----
`default_nettype none
module psgm_gain_engine
  import psgm_pkg::*;
#(
  parameter int POSITION_WIDTH = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [POSITION_WIDTH-1:0] cfg_data,
  output gains_t                         gains
);

  localparam int P = POSITION_WIDTH;
  localparam int XW = P + 4;

  localparam logic [2:0] ST_SQUARE  = 3'd0;
  localparam logic [2:0] ST_ATAN    = 3'd1;
  localparam logic [2:0] ST_FOLD    = 3'd2;
  localparam logic [2:0] ST_SINE    = 3'd3;
  localparam logic [2:0] ST_PRODUCT = 3'd4;
  localparam logic [2:0] ST_SCALE   = 3'd5;
  localparam logic [2:0] ST_DIVIDE  = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic signed [32:0] QUARTER_S = 33'sh0_4000_0000;
  localparam logic signed [32:0] HALF_S = 33'sh0_8000_0000;

  logic [2:0] state;
  logic [4:0] cnt;
  logic       side;
  logic       div_start;

  logic signed [P-1:0] src_x, src_y, src_z, lst_x, lst_y, lst_z;
  logic [15:0] facing, volume;

  logic signed [P:0] dx, dy, dz;
  logic [P-1:0] mag_x, mag_y, mag_z, mag_sel;

  logic [2*P-1:0]  prod;
  logic [R2_W-1:0] r2;
  logic [R2_W:0]   r2_sum;
  logic            near;

  logic signed [XW-1:0] cx, cy, cxs, cys;
  logic [31:0]          cz;
  logic signed [33:0]   sx, sy, sxs, sys;
  logic signed [32:0]   sa, ang_s;

  logic [31:0]        bear, theta;
  logic signed [32:0] th_s, fold;

  logic signed [33:0] bsum, bq;
  logic signed [17:0] bc, onepm_l, onepm_r;
  logic [32:0]        p_left, p_right, p_sel;
  logic [NUM_W-1:0]   div_num, div_q;
  logic               div_done;
  logic [15:0]        gain_left, gain_right;

  function automatic logic [15:0] clamp_gain(input logic [NUM_W-1:0] q);
    return (q > NUM_W'(UNITY_GAIN)) ? UNITY_GAIN : q[15:0];
  endfunction

  assign dx = (P+1)'(src_x) - (P+1)'(lst_x);
  assign dy = (P+1)'(src_y) - (P+1)'(lst_y);
  assign dz = (P+1)'(src_z) - (P+1)'(lst_z);
  assign mag_x = dx[P] ? P'(-dx) : P'(dx);
  assign mag_y = dy[P] ? P'(-dy) : P'(dy);
  assign mag_z = dz[P] ? P'(-dz) : P'(dz);

  always_comb begin
    case (cnt[1:0])
      2'd0: mag_sel = mag_x;
      2'd1: mag_sel = mag_y;
      2'd2: mag_sel = mag_z;
      default: mag_sel = '0;
    endcase
  end

  assign r2_sum = {1'b0, r2} + (R2_W+1)'(prod);
  assign near = r2 <= NEAR_LIMIT;

  assign cxs = cx >>> cnt;
  assign cys = cy >>> cnt;
  assign sxs = sx >>> cnt;
  assign sys = sy >>> cnt;
  assign ang_s = $signed({1'b0, atan_angle(cnt)});

  // fold the first-quadrant angle into the quadrant of (dx, dy)
  always_comb begin
    bear = cz;
    if (dx[P] && !dy[P]) begin
      bear = HALF_TURN - cz;
    end else if (dx[P]) begin
      bear = HALF_TURN + cz;
    end else if (dy[P]) begin
      bear = 32'd0 - cz;
    end
    if (dx == '0 && dy == '0) begin
      bear = '0;
    end
    theta = bear - {facing, 16'h0000};
    th_s = $signed({theta[31], theta});
    fold = th_s;
    if (th_s > QUARTER_S) begin
      fold = HALF_S - th_s;
    end else if (th_s < -QUARTER_S) begin
      fold = -HALF_S - th_s;
    end
  end

  always_comb begin
    bsum = sy + 34'sd16384;
    bq = bsum >>> 15;
    if (bq > 34'sd32768) begin
      bc = 18'sd32768;
    end else if (bq < -34'sd32768) begin
      bc = -18'sd32768;
    end else begin
      bc = bq[17:0];
    end
    onepm_l = 18'sd32768 + bc;
    onepm_r = 18'sd32768 - bc;
  end

  assign p_sel = side ? p_right : p_left;
  assign div_num = (NUM_W'(p_sel) << 5) + (NUM_W'(p_sel) << 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SQUARE;
      cnt       <= '0;
      side      <= 1'b0;
      div_start <= 1'b0;
      src_x     <= '0;
      src_y     <= '0;
      src_z     <= '0;
      lst_x     <= '0;
      lst_y     <= '0;
      lst_z     <= '0;
      facing    <= FACING_RESET;
      volume    <= VOLUME_RESET;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SOURCE_X:   src_x <= cfg_data;
          REG_SOURCE_Y:   src_y <= cfg_data;
          REG_SOURCE_Z:   src_z <= cfg_data;
          REG_LISTENER_X: lst_x <= cfg_data;
          REG_LISTENER_Y: lst_y <= cfg_data;
          REG_LISTENER_Z: lst_z <= cfg_data;
          REG_FACING:     facing <= cfg_data[15:0];
          REG_VOLUME:     volume <= cfg_data[15:0];
          default: ;
        endcase
        // recompute from scratch
        state <= ST_SQUARE;
        cnt   <= '0;
      end else begin
        unique case (state)
          ST_SQUARE: begin
            if (cnt == SQUARE_LAST) begin
              state <= ST_ATAN;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          ST_ATAN: begin
            if (cnt == ROUND_LAST) begin
              state <= ST_FOLD;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          ST_FOLD: state <= ST_SINE;
          ST_SINE: begin
            if (cnt == ROUND_LAST) begin
              state <= ST_PRODUCT;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          ST_PRODUCT: state <= ST_SCALE;
          ST_SCALE: begin
            if (near) begin
              state <= ST_DONE;
            end else begin
              state     <= ST_DIVIDE;
              side      <= 1'b0;
              div_start <= 1'b1;
            end
          end
          ST_DIVIDE: begin
            if (div_done) begin
              if (!side) begin
                side      <= 1'b1;
                div_start <= 1'b1;
              end else begin
                state <= ST_DONE;
              end
            end
          end
          ST_DONE: ;
          default: state <= ST_SQUARE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_SQUARE: begin
        prod <= mag_sel * mag_sel;
        // saturate the sum of squares
        r2 <= (cnt == '0) ? '0 : (r2_sum[R2_W] ? '1 : r2_sum[R2_W-1:0]);
        cx <= XW'(mag_x);
        cy <= XW'(mag_y);
        cz <= '0;
      end
      ST_ATAN: begin
        if (!cy[XW-1]) begin
          cx <= cx + cys;
          cy <= cy - cxs;
          cz <= cz + atan_angle(cnt);
        end else begin
          cx <= cx - cys;
          cy <= cy + cxs;
          cz <= cz - atan_angle(cnt);
        end
      end
      ST_FOLD: begin
        sx <= $signed({2'b00, CORDIC_K_Q30});
        sy <= '0;
        sa <= fold;
      end
      ST_SINE: begin
        if (!sa[32]) begin
          sx <= sx - sys;
          sy <= sy + sxs;
          sa <= sa - ang_s;
        end else begin
          sx <= sx + sys;
          sy <= sy - sxs;
          sa <= sa + ang_s;
        end
      end
      ST_PRODUCT: begin
        p_left  <= volume * onepm_l[16:0];
        p_right <= volume * onepm_r[16:0];
      end
      ST_SCALE: begin
        gain_left  <= clamp_gain(NUM_W'(p_left[32:15]));
        gain_right <= clamp_gain(NUM_W'(p_right[32:15]));
      end
      ST_DIVIDE: begin
        if (div_done) begin
          if (side) begin
            gain_right <= clamp_gain(div_q);
          end else begin
            gain_left <= clamp_gain(div_q);
          end
        end
      end
      default: ;
    endcase
  end

  psgm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .flush    (cfg_we),
    .start    (div_start),
    .num      (div_num),
    .den      (r2),
    .done     (div_done),
    .quotient (div_q)
  );

  assign gains.ready = (state == ST_DONE);
  assign gains.left  = gain_left;
  assign gains.right = gain_right;

endmodule
`default_nettype wire

// ----- design/psgm_mix_pipe.sv -----
`default_nettype none
module psgm_mix_pipe
  import psgm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire in_beat_t in_data,
  output logic          ready,
  input  wire gains_t   gains,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_data
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  in_beat_t d1;
  logic signed [32:0] pl2, pr2;
  logic signed [15:0] ml2, mr2;

  assign rdy3 = !v3 || !out_stall;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign ready = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= take;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d1 <= in_data;
    end
    if (rdy2) begin
      pl2 <= d1.sample * $signed({1'b0, gains.left});
      pr2 <= d1.sample * $signed({1'b0, gains.right});
      ml2 <= d1.mix_left_in;
      mr2 <= d1.mix_right_in;
    end
    // floor shift by 16, sum wraps to 16 bits
    if (rdy3) begin
      out_data.mix_left_out  <= ml2 + pl2[31:16];
      out_data.mix_right_out <= mr2 + pr2[31:16];
    end
  end

endmodule
`default_nettype wire

// ----- design/positional_stereo_gain_mixer.sv -----
// Mixes a mono sample into a stereo pair with position-derived gains.
// Input channel: in_valid / in_stall carry in_data (sample, mix_left_in,
// mix_right_in). Output channel: out_valid / out_stall carry out_data.
// Configuration: cfg_we writes cfg_data to register cfg_index (positions,
// facing, volume); write only while no beat is in flight.
// Throughput: one beat per cycle through the 3-stage mix pipeline, as long
// as neither out_stall nor in_stall holds the flow.
// After reset and after every configuration write the gain sequencer
// recomputes both gains and in_stall stays high meanwhile: squares, 17
// bearing and 17 sine CORDIC steps when the source is near, plus one
// division per side when it is far.
// Reset clears the pipeline and loads default registers.
// A stalled output holds its beat; bubbles collapse, and input backs up
// when all stages are full, while gains recompute or during a cfg write.
`default_nettype none
module positional_stereo_gain_mixer
  import psgm_pkg::*;
#(
  parameter int POSITION_WIDTH = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_beat_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_beat_t                      out_data,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [POSITION_WIDTH-1:0] cfg_data
);

`include "positional_stereo_gain_mixer_defines.svh"

  gains_t gains;
  logic   pipe_ready;
  logic   take;

  assign in_stall = !(pipe_ready && gains.ready && !cfg_we);
  assign take = in_valid && !in_stall;

  psgm_gain_engine #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_gain_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  psgm_mix_pipe u_mix_pipe (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_data   (in_data),
    .ready     (pipe_ready),
    .gains     (gains),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `PSGM_ASSERT_NOW(a_no_take_on_cfg, cfg_we, in_stall, "beat taken during config write")
  `PSGM_ASSERT_NEXT(a_cfg_restarts, cfg_we, !gains.ready, "config write kept stale gains")
  `PSGM_ASSERT_NOW(a_take_needs_gains, take, gains.ready, "beat taken before gains ready")

endmodule
`default_nettype wire
